FILE: hw/rtl/lvr_pkg.sv
package lvr_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 24;
   localparam logic [23:0] RADIUS_MAX = 24'hFFFFFF;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_QUAD_ZERO = 2'd1,
      ST_NEG_DISC = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   // square-root stage: one root bit per stage
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [15:0] kl;
      logic [15:0] kq;
      logic [34:0] rem;
      logic [31:0] root;
      logic [63:0] v;
   } sq_type;

   // division stage: one quotient bit per stage
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic        dead;
      logic        sat;
      logic [18:0] d;
      logic [19:0] rem;
      logic [23:0] low;
      logic [23:0] q;
   } dv_type;

endpackage

FILE: hw/rtl/light_volume_radius_core.sv
// light_volume_radius_core: radius of influence of one point light.
//
// Input channel req_*: one item per light (three 4.12 intensities, kc 8.8,
// kl and kq 0.16). Result channel rsp_*: 16.8 radius and a 2-bit status
// (ok, quadratic zero, negative discriminant, saturated).
//
// The item passes 61 pipeline registers: stage 1, stage 2, the square root,
// the divider and the result register. Throughput is one item per clock
// while the receiver does not stall: every stage holds its own item, so a
// new item enters each cycle. Depth is set by the square root (one root bit
// per stage, 32 stages plus an entry stage) and the divider (one quotient
// bit per stage, 24 stages plus an entry stage).
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated. Reset clears every
// stage valid bit; payload registers keep whatever they hold.
module light_volume_radius_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lowest bit up: intensity_red, intensity_green, intensity_blue,
   // atten_constant, atten_linear, atten_quadratic (16 bits each)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // lowest bit up: radius[23:0], status[25:24], zero fill
   output logic [31:0] rsp_tdata
);

   localparam int SQ = lvr_pkg::SQRT_STEPS;
   localparam int DV = lvr_pkg::DIV_STEPS;

   logic adv;

   // stage 1: intensity sum, constant term, kl squared
   logic                s1_valid_ff;
   lvr_pkg::status_type s1_status_ff;
   logic signed [27:0]  s1_cn_ff;
   logic [31:0]         s1_klsq_ff;
   logic [15:0]         s1_kl_ff, s1_kq_ff;

   // stage 2: discriminant numerator
   logic                s2_valid_ff;
   lvr_pkg::status_type s2_status_ff;
   logic signed [51:0]  s2_dn_ff;
   logic [15:0]         s2_kl_ff, s2_kq_ff;

   lvr_pkg::sq_type sq_ff [0:SQ];
   lvr_pkg::sq_type sq_in [0:SQ];
   lvr_pkg::dv_type dv_ff [0:DV];
   lvr_pkg::dv_type dv_in [0:DV];

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic [15:0] ir, ig, ib, kc, kl, kq;
   logic [17:0] sum;
   logic [27:0] cn_pos, cn_neg;
   logic signed [27:0] s1_cn_in;
   logic signed [44:0] prod;
   logic signed [51:0] prod_sh;
   logic [51:0] five_klsq;
   logic signed [51:0] s2_dn_in;
   lvr_pkg::status_type s1_status_in;

   // stage math feeding the division
   logic [31:0] s_root;
   logic [24:0] lin;
   logic [32:0] n_val;
   logic [33:0] two_n;
   logic [18:0] dsr;
   logic [42:0] sat_lim;
   lvr_pkg::status_type fin_status;
   logic [23:0] fin_radius;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign ir = req_tdata[15:0];
   assign ig = req_tdata[31:16];
   assign ib = req_tdata[47:32];
   assign kc = req_tdata[63:48];
   assign kl = req_tdata[79:64];
   assign kq = req_tdata[95:80];

   always_comb begin
      sum          = 18'(ir) + 18'(ig) + 18'(ib);
      cn_pos       = 28'(kc) * 28'd80;
      cn_neg       = {2'b0, sum, 8'b0};
      s1_cn_in     = $signed(cn_pos - cn_neg);
      s1_status_in = (kq == 16'd0) ? lvr_pkg::ST_QUAD_ZERO : lvr_pkg::ST_OK;
      prod         = s1_cn_ff * $signed({1'b0, s1_kq_ff});
      prod_sh      = {prod[44], prod, 6'b0};
      five_klsq    = 52'(s1_klsq_ff) * 52'd5;
      s2_dn_in     = $signed(five_klsq) - prod_sh;
   end

   // square root: entry stage forms 5*Dn*4096, then one root bit per stage
   always_comb begin
      logic [51:0] e;
      logic [34:0] r2, trial;
      e = {s2_dn_ff[49:0], 2'b0} + 52'(unsigned'(s2_dn_ff));
      sq_in[0].valid  = s2_valid_ff;
      sq_in[0].status = (s2_status_ff == lvr_pkg::ST_OK && s2_dn_ff < 0) ?
                        lvr_pkg::ST_NEG_DISC : s2_status_ff;
      sq_in[0].kl     = s2_kl_ff;
      sq_in[0].kq     = s2_kq_ff;
      sq_in[0].rem    = '0;
      sq_in[0].root   = '0;
      sq_in[0].v      = {e, 12'b0};
      for (int k = 1; k <= SQ; k++) begin
         r2    = {sq_ff[k-1].rem[32:0], sq_ff[k-1].v[63:62]};
         trial = {1'b0, sq_ff[k-1].root, 2'b01};
         sq_in[k]   = sq_ff[k-1];
         sq_in[k].v = {sq_ff[k-1].v[61:0], 2'b0};
         if (r2 >= trial) begin
            sq_in[k].rem  = r2 - trial;
            sq_in[k].root = {sq_ff[k-1].root[30:0], 1'b1};
         end else begin
            sq_in[k].rem  = r2;
            sq_in[k].root = {sq_ff[k-1].root[30:0], 1'b0};
         end
      end
   end

   // divider: entry stage takes s - 320*kl and checks saturation
   always_comb begin
      logic [19:0] r2;
      s_root  = sq_ff[SQ].root;
      lin     = 25'(sq_ff[SQ].kl) * 25'd320;
      n_val   = (33'(s_root) > 33'(lin)) ? 33'(s_root) - 33'(lin) : 33'd0;
      two_n   = {n_val, 1'b0};
      dsr     = 19'(sq_ff[SQ].kq) * 19'd5;
      sat_lim = {dsr, 24'b0};
      dv_in[0].valid  = sq_ff[SQ].valid;
      dv_in[0].status = sq_ff[SQ].status;
      dv_in[0].dead   = (n_val == 33'd0);
      dv_in[0].sat    = (43'(two_n) >= sat_lim);
      dv_in[0].d      = dsr;
      dv_in[0].rem    = 20'(two_n[33:24]);
      dv_in[0].low    = two_n[23:0];
      dv_in[0].q      = '0;
      for (int k = 1; k <= DV; k++) begin
         r2 = {dv_ff[k-1].rem[18:0], dv_ff[k-1].low[23]};
         dv_in[k]     = dv_ff[k-1];
         dv_in[k].low = {dv_ff[k-1].low[22:0], 1'b0};
         if (r2 >= 20'(dv_ff[k-1].d)) begin
            dv_in[k].rem = r2 - 20'(dv_ff[k-1].d);
            dv_in[k].q   = {dv_ff[k-1].q[22:0], 1'b1};
         end else begin
            dv_in[k].rem = r2;
            dv_in[k].q   = {dv_ff[k-1].q[22:0], 1'b0};
         end
      end
   end

   // final select: error codes force zero, saturation clamps
   always_comb begin
      fin_status = dv_ff[DV].status;
      fin_radius = 24'd0;
      if (dv_ff[DV].status == lvr_pkg::ST_OK && !dv_ff[DV].dead) begin
         if (dv_ff[DV].sat) begin
            fin_radius = lvr_pkg::RADIUS_MAX;
            fin_status = lvr_pkg::ST_SATURATED;
         end else begin
            fin_radius = dv_ff[DV].q;
         end
      end
   end

   // valid bits clear on reset; payload advances with the pipeline and
   // holds on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= SQ; k++) sq_ff[k].valid <= 1'b0;
         for (int k = 0; k <= DV; k++) dv_ff[k].valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= dv_ff[DV].valid;
         for (int k = 0; k <= SQ; k++) sq_ff[k].valid <= sq_in[k].valid;
         for (int k = 0; k <= DV; k++) dv_ff[k].valid <= dv_in[k].valid;
      end
      if (adv) begin
         s1_status_ff <= s1_status_in;
         s1_cn_ff     <= s1_cn_in;
         s1_klsq_ff   <= 32'(kl) * 32'(kl);
         s1_kl_ff     <= kl;
         s1_kq_ff     <= kq;
         s2_status_ff <= s1_status_ff;
         s2_dn_ff     <= s2_dn_in;
         s2_kl_ff     <= s1_kl_ff;
         s2_kq_ff     <= s1_kq_ff;
         for (int k = 0; k <= SQ; k++) begin
            sq_ff[k].status <= sq_in[k].status;
            sq_ff[k].kl     <= sq_in[k].kl;
            sq_ff[k].kq     <= sq_in[k].kq;
            sq_ff[k].rem    <= sq_in[k].rem;
            sq_ff[k].root   <= sq_in[k].root;
            sq_ff[k].v      <= sq_in[k].v;
         end
         for (int k = 0; k <= DV; k++) begin
            dv_ff[k].status <= dv_in[k].status;
            dv_ff[k].dead   <= dv_in[k].dead;
            dv_ff[k].sat    <= dv_in[k].sat;
            dv_ff[k].d      <= dv_in[k].d;
            dv_ff[k].rem    <= dv_in[k].rem;
            dv_ff[k].low    <= dv_in[k].low;
            dv_ff[k].q      <= dv_in[k].q;
         end
         rsp_data_ff <= {6'b0, fin_status, fin_radius};
      end
   end

   // error codes never carry a radius
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[25:24] == lvr_pkg::ST_QUAD_ZERO ||
                     rsp_tdata[25:24] == lvr_pkg::ST_NEG_DISC)
      |-> rsp_tdata[23:0] == 24'd0)
      else $error("error status with nonzero radius");

   // saturation always clamps to the top value
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25:24] == lvr_pkg::ST_SATURATED
      |-> rsp_tdata[23:0] == lvr_pkg::RADIUS_MAX)
      else $error("saturated status without clamped radius");

   // a stalled result blocks intake and holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready ##1 $stable(rsp_tdata))
      else $error("pipeline moved during stall");

endmodule

FILE: tb/light_volume_radius_core_tb.sv
`timescale 1ns / 100ps

module light_volume_radius_core_tb;

   typedef struct packed {
      logic [15:0] kq;
      logic [15:0] kl;
      logic [15:0] kc;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } light_type;

   typedef struct {
      logic [23:0]         radius;
      lvr_pkg::status_type status;
   } radius_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // lowest bit up: red, green, blue, kc, kl, kq (16 bits each)
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // lowest bit up: radius[23:0], status[25:24], zero fill
   logic [31:0] rsp_tdata;

   light_type  light_queue[$];
   radius_type radius_queue[$];
   int         fail_count;
   int         idle_left;
   int         stall_left;
   bit         hold_off;
   bit         drain_request;
   bit         stim_done;

   light_volume_radius_core DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // integer square root, floor
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic radius_type light_radius(input light_type l);
      radius_type  res;
      longint      cn;
      longint      dn;
      logic [63:0] s;
      logic [63:0] lin;
      logic [63:0] q;
      res.radius = '0;
      res.status = lvr_pkg::ST_OK;
      if (l.kq == 0) begin
         res.status = lvr_pkg::ST_QUAD_ZERO;
      end else begin
         cn = 80 * longint'(l.kc) - 256 * (longint'(l.red) + l.green + l.blue);
         dn = 5 * (longint'(l.kl) * l.kl) - 64 * longint'(l.kq) * cn;
         if (dn < 0) begin
            res.status = lvr_pkg::ST_NEG_DISC;
         end else begin
            s   = root_floor(64'(dn) * 5 * 4096);
            lin = 320 * 64'(l.kl);
            if (s > lin) begin
               q = (2 * (s - lin)) / (5 * 64'(l.kq));
               if (q > 64'(lvr_pkg::RADIUS_MAX)) begin
                  res.radius = lvr_pkg::RADIUS_MAX;
                  res.status = lvr_pkg::ST_SATURATED;
               end else begin
                  res.radius = q[23:0];
               end
            end
         end
      end
      return res;
   endfunction

   function automatic int gap_length();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
   endfunction

   task automatic report(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   // driver: pop the next light, offer it, hold until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left  <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered item
      end else if (idle_left > 0) begin
         req_tvalid <= 1'b0;
         idle_left  <= idle_left - 1;
      end else if (light_queue.size() > 0 && !(drain_request && radius_queue.size() > 0)) begin
         light_type l;
         l = light_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= l;
         radius_queue.push_back(light_radius(l));
         idle_left  <= ($urandom_range(0, 3) == 0) ? gap_length() : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 4) == 0) stall_left <= gap_length();
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (radius_queue.size() == 0) begin
            report("result with nothing expected");
         end else begin
            radius_type e;
            e = radius_queue.pop_front();
            if (rsp_tdata[23:0] !== e.radius)
               report($sformatf("radius %h, expected %h", rsp_tdata[23:0], e.radius));
            if (rsp_tdata[25:24] !== e.status)
               report($sformatf("status %0d, expected %0d", rsp_tdata[25:24], e.status));
         end
      end
   end

   function automatic light_type random_light();
      light_type l;
      l = {$urandom, $urandom, $urandom};
      case ($urandom_range(0, 5))
         0: l.kq = 16'd0;
         1: begin
            // small intensities, strong constant: often negative discriminant
            l.red = 16'($urandom_range(0, 255));
            l.green = 16'd0;
            l.blue = 16'd0;
         end
         2: begin
            // tiny kq with bright light: saturates
            l.kq = 16'($urandom_range(1, 4));
            l.kl = 16'($urandom_range(0, 64));
         end
         3: begin
            // realistic: modest factors
            l.kc = 16'h0100;
            l.kl = 16'($urandom_range(0, 16'h2000));
            l.kq = 16'($urandom_range(1, 16'h1000));
         end
         default: ;
      endcase
      return l;
   endfunction

   initial begin
      light_type l;
      int        w;
      reset         = 1'b1;
      drain_request = 1'b0;
      stim_done     = 1'b0;
      fail_count    = 0;
      // directed: extremes and every status
      light_queue.push_back('0);
      light_queue.push_back('1);
      l = '1; l.kq = 0; light_queue.push_back(l);
      l = '0; l.kq = 1; light_queue.push_back(l);
      l = '0; l.kq = 16'hFFFF; l.kc = 16'hFFFF; light_queue.push_back(l);
      l = '0; l.kq = 1; l.red = 16'hFFFF; l.green = 16'hFFFF; l.blue = 16'hFFFF;
      light_queue.push_back(l);
      l = '0; l.kq = 1; l.kl = 16'hFFFF; light_queue.push_back(l);
      l = '0; l.kq = 16'h0100; l.kc = 16'h0100; l.kl = 16'h0800; l.red = 16'h1000;
      light_queue.push_back(l);
      l = '0; l.kq = 16'h8000; l.kc = 16'hFFFF; l.kl = 16'hFFFF; light_queue.push_back(l);
      l = '1; l.kc = 0; light_queue.push_back(l);
      l = '0; l.kq = 16'hFFFF; l.kl = 16'hFFFF; l.red = 16'hFFFF; light_queue.push_back(l);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (w = 0; w < 800; w++) begin
         light_queue.push_back(random_light());
         if (w == 200) begin
            // long receiver hold-off while the sender keeps offering
            wait (light_queue.size() == 0);
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         if (w == 500) begin
            // sender pauses until every result has come back
            wait (light_queue.size() == 0);
            drain_request = 1'b1;
            wait (radius_queue.size() == 0);
            drain_request = 1'b0;
         end
      end
      wait (light_queue.size() == 0 && !req_tvalid);
      wait (radius_queue.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
